FILE: rtl/core/brle_pkg.sv
`timescale 1ns / 1ps

package brle_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_ROWS  = 4096;

  localparam int COL_W = 13;
  localparam int ROW_W = 12;
  localparam int OUT_COL_W = 12;

  localparam logic [COL_W-1:0] COL_SAT  = 13'd8191;
  localparam logic [COL_W-1:0] WIDTH_CAP = 13'((MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH);
  localparam logic [COL_W-1:0] ROW_WIDTH_RST = 13'd4096;
  localparam logic [ROW_W-1:0] ROW_CAP  = 12'(((MAX_ROWS > 4096) ? 4096 : MAX_ROWS) - 1);
  localparam logic [COL_W-1:0] OUT_COL_SAT = 13'd4095;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam logic [1:0] SEG_FILL = 2'd0;
  localparam logic [1:0] SEG_LIT  = 2'd1;
  localparam logic [1:0] SEG_EOL  = 2'd2;
  localparam logic [1:0] SEG_EOB  = 2'd3;

  localparam logic [1:0] CFG_RLE4_MODE = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH = 2'd1;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_FILL  = 3'd1,
    OP_LIT   = 3'd2,
    OP_EOL   = 3'd3,
    OP_EOB   = 3'd4,
    OP_DELTA = 3'd5
  } op_t;

  // For a delta, count carries dx and value carries dy.
  typedef struct packed {
    logic       sof;
    op_t        op;
    logic [7:0] count;
    logic [7:0] value;
  } cmd_t;

endpackage

FILE: rtl/core/brle_front.sv
`timescale 1ns / 1ps

module brle_front
  import brle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rle4_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       in_start_of_image,
  input  logic       cq_full,
  output logic       cq_push,
  output cmd_t       cq_cmd
);

  typedef enum logic [5:0] {
    PH_FIRST  = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_DX     = 6'b000100,
    PH_DY     = 6'b001000,
    PH_LIT    = 6'b010000,
    PH_PAD    = 6'b100000
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_cur;
  logic [7:0] held_r, held_nxt, held_cur;
  logic [7:0] left_r, left_nxt, left_cur;
  logic [7:0] total_r, total_nxt, total_cur;
  logic       done_r, done_nxt, done_cur;
  logic       accept;
  logic [1:0] lit_n;
  logic [7:0] left_sub;
  logic [8:0] total_p1;
  logic       pad_needed;
  cmd_t       cmd;

  assign in_ready = !cq_full;
  assign accept   = in_valid && in_ready;

  assign phase_cur = in_start_of_image ? PH_FIRST : phase_r;
  assign held_cur  = in_start_of_image ? 8'd0 : held_r;
  assign left_cur  = in_start_of_image ? 8'd0 : left_r;
  assign total_cur = in_start_of_image ? 8'd0 : total_r;
  assign done_cur  = in_start_of_image ? 1'b0 : done_r;

  always_comb begin
    if (rle4_mode) begin
      lit_n = (left_cur >= 8'd2) ? 2'd2 : left_cur[1:0];
    end else begin
      lit_n = (left_cur >= 8'd1) ? 2'd1 : 2'd0;
    end
  end

  assign left_sub   = left_cur - {6'd0, lit_n};
  assign total_p1   = {1'b0, total_cur} + 9'd1;
  assign pad_needed = rle4_mode ? total_p1[1] : total_cur[0];

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    left_nxt  = left_r;
    total_nxt = total_r;
    done_nxt  = done_r;
    cmd.sof   = in_start_of_image;
    cmd.op    = OP_NONE;
    cmd.count = 8'd0;
    cmd.value = 8'd0;
    if (accept) begin
      phase_nxt = phase_cur;
      held_nxt  = held_cur;
      left_nxt  = left_cur;
      total_nxt = total_cur;
      done_nxt  = done_cur;
      if (!done_cur) begin
        unique case (phase_cur)
          PH_FIRST: begin
            held_nxt  = in_stream_byte;
            phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            phase_nxt = PH_FIRST;
            if (held_cur != 8'd0) begin
              cmd.op    = OP_FILL;
              cmd.count = held_cur;
              cmd.value = in_stream_byte;
            end else if (in_stream_byte == ESC_EOL) begin
              cmd.op = OP_EOL;
            end else if (in_stream_byte == ESC_EOB) begin
              cmd.op   = OP_EOB;
              done_nxt = 1'b1;
            end else if (in_stream_byte == ESC_DELTA) begin
              phase_nxt = PH_DX;
            end else begin
              left_nxt  = in_stream_byte;
              total_nxt = in_stream_byte;
              phase_nxt = PH_LIT;
            end
          end
          PH_DX: begin
            held_nxt  = in_stream_byte;
            phase_nxt = PH_DY;
          end
          PH_DY: begin
            cmd.op    = OP_DELTA;
            cmd.count = held_cur;
            cmd.value = in_stream_byte;
            phase_nxt = PH_FIRST;
          end
          PH_LIT: begin
            cmd.op    = OP_LIT;
            cmd.count = {6'd0, lit_n};
            cmd.value = in_stream_byte;
            left_nxt  = left_sub;
            if (left_sub == 8'd0) begin
              phase_nxt = pad_needed ? PH_PAD : PH_FIRST;
            end
          end
          PH_PAD: begin
            phase_nxt = PH_FIRST;
          end
          default: begin
            phase_nxt = PH_FIRST;
          end
        endcase
      end
    end
  end

  assign cq_cmd  = cmd;
  assign cq_push = accept && (cmd.sof || (cmd.op != OP_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held_r  <= 8'd0;
      left_r  <= 8'd0;
      total_r <= 8'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

FILE: rtl/core/brle_cmdq.sv
`timescale 1ns / 1ps

module brle_cmdq
  import brle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic empty,
  input  logic pop,
  output cmd_t head_cmd
);

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CQ_CW'(CQ_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/brle_back.sv
`timescale 1ns / 1ps

module brle_back
  import brle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [COL_W-1:0]     row_width,
  input  logic                 cq_empty,
  input  cmd_t                 cq_head,
  output logic                 cq_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_segment_kind,
  output logic [ROW_W-1:0]     out_row_index,
  output logic [OUT_COL_W-1:0] out_start_column,
  output logic [7:0]           out_pixel_count,
  output logic [7:0]           out_pixel_value,
  output logic                 out_clipped
);

  logic [COL_W-1:0]     col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]     row_r, row_nxt, row_cur;
  logic                 valid_r, valid_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [ROW_W-1:0]     orow_r, orow_nxt;
  logic [OUT_COL_W-1:0] ocol_r, ocol_nxt;
  logic [7:0]           cnt_r, cnt_nxt;
  logic [7:0]           val_r, val_nxt;
  logic                 clip_r, clip_nxt;

  logic                 emits;
  logic                 slot_free;
  logic [COL_W-1:0]     eff_w;
  logic [COL_W-1:0]     avail;
  logic [COL_W-1:0]     n_ext;
  logic [7:0]           keep;
  logic                 clip;
  logic [COL_W:0]       col_sum;
  logic [ROW_W:0]       row_sum;
  logic [7:0]           row_add;

  assign emits     = (cq_head.op == OP_FILL) || (cq_head.op == OP_LIT) ||
                     (cq_head.op == OP_EOL) || (cq_head.op == OP_EOB);
  assign slot_free = !valid_r || out_ready;
  assign cq_pop    = !cq_empty && (!emits || slot_free);

  assign col_cur = cq_head.sof ? '0 : col_r;
  assign row_cur = cq_head.sof ? '0 : row_r;

  assign eff_w = (row_width > WIDTH_CAP) ? WIDTH_CAP : row_width;
  assign avail = (col_cur < eff_w) ? (eff_w - col_cur) : '0;
  assign n_ext = {{(COL_W-8){1'b0}}, cq_head.count};
  assign keep  = (n_ext < avail) ? cq_head.count : avail[7:0];
  assign clip  = (n_ext > avail);

  assign col_sum = {1'b0, col_cur} + {1'b0, n_ext};
  assign row_add = (cq_head.op == OP_EOL) ? 8'd1 : cq_head.value;
  assign row_sum = {1'b0, row_cur} + {{(ROW_W-7){1'b0}}, row_add};

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    valid_nxt = valid_r && !out_ready;
    kind_nxt  = kind_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    clip_nxt  = clip_r;
    if (cq_pop) begin
      col_nxt = col_cur;
      row_nxt = row_cur;
      if (emits) begin
        valid_nxt = 1'b1;
        orow_nxt  = row_cur;
        ocol_nxt  = (col_cur > OUT_COL_SAT) ? OUT_COL_SAT[OUT_COL_W-1:0]
                                            : col_cur[OUT_COL_W-1:0];
        cnt_nxt   = 8'd0;
        val_nxt   = 8'd0;
        clip_nxt  = 1'b0;
      end
      unique case (cq_head.op)
        OP_FILL, OP_LIT: begin
          kind_nxt = (cq_head.op == OP_FILL) ? SEG_FILL : SEG_LIT;
          cnt_nxt  = keep;
          val_nxt  = cq_head.value;
          clip_nxt = clip;
          col_nxt  = (col_sum > {1'b0, COL_SAT}) ? COL_SAT : col_sum[COL_W-1:0];
        end
        OP_EOL: begin
          kind_nxt = SEG_EOL;
          row_nxt  = (row_sum > {1'b0, ROW_CAP}) ? ROW_CAP : row_sum[ROW_W-1:0];
          col_nxt  = '0;
        end
        OP_EOB: begin
          kind_nxt = SEG_EOB;
        end
        OP_DELTA: begin
          col_nxt = (col_sum > {1'b0, COL_SAT}) ? COL_SAT : col_sum[COL_W-1:0];
          row_nxt = (row_sum > {1'b0, ROW_CAP}) ? ROW_CAP : row_sum[ROW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    cnt_r  <= cnt_nxt;
    val_r  <= val_nxt;
    clip_r <= clip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_segment_kind = kind_r;
  assign out_row_index    = orow_r;
  assign out_start_column = ocol_r;
  assign out_pixel_count  = cnt_r;
  assign out_pixel_value  = val_r;
  assign out_clipped      = clip_r;

endmodule

FILE: rtl/core/bmp_rle_stream_decoder_top.sv
// Takes one compressed byte per cycle while the command queue is not full; a segment
// passes through the command queue and the output register after its last byte.
// Throughput is one byte per cycle while the queue has room, set by the parse step and
// the row and column update behind a two-entry command queue. Synchronous active-low
// reset clears the parse phase, row, column, queue and output valid, and sets RLE8 mode with a row width of 4096.
`timescale 1ns / 1ps

module bmp_rle_stream_decoder_top
  import brle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [COL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_stream_byte,
  input  logic                 in_start_of_image,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_segment_kind,
  output logic [ROW_W-1:0]     out_row_index,
  output logic [OUT_COL_W-1:0] out_start_column,
  output logic [7:0]           out_pixel_count,
  output logic [7:0]           out_pixel_value,
  output logic                 out_clipped
);

  logic             rle4_mode_r;
  logic [COL_W-1:0] row_width_r;
  logic             cq_push, cq_pop, cq_full, cq_empty;
  cmd_t             cq_cmd, cq_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle4_mode_r <= 1'b0;
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RLE4_MODE: rle4_mode_r <= cfg_data[0];
        CFG_ROW_WIDTH: row_width_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  brle_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .rle4_mode         (rle4_mode_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .in_start_of_image (in_start_of_image),
    .cq_full           (cq_full),
    .cq_push           (cq_push),
    .cq_cmd            (cq_cmd)
  );

  brle_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_cmd),
    .full     (cq_full),
    .empty    (cq_empty),
    .pop      (cq_pop),
    .head_cmd (cq_head)
  );

  brle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .row_width        (row_width_r),
    .cq_empty         (cq_empty),
    .cq_head          (cq_head),
    .cq_pop           (cq_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segment_kind (out_segment_kind),
    .out_row_index    (out_row_index),
    .out_start_column (out_start_column),
    .out_pixel_count  (out_pixel_count),
    .out_pixel_value  (out_pixel_value),
    .out_clipped      (out_clipped)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import brle_pkg::*;

  localparam int ROW_LIMIT = ((MAX_ROWS > 4096) ? 4096 : MAX_ROWS) - 1;
  localparam int COL_LIMIT = 8191;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES = 140;
  localparam logic [7:0] ESCAPE = 8'h00;

  typedef enum logic [2:0] {
    P_FIRST,
    P_SECOND,
    P_DX,
    P_DY,
    P_LIT,
    P_PAD
  } dec_phase_t;

  typedef struct packed {
    logic       sof;
    logic [7:0] b;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  cnt;
    logic [7:0]  val;
    logic        clip;
  } seg_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_RLE4_MODE;
  logic [COL_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_stream_byte = 8'h00;
  logic              in_start_of_image = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_segment_kind;
  logic [ROW_W-1:0]  out_row_index;
  logic [OUT_COL_W-1:0] out_start_column;
  logic [7:0]        out_pixel_count;
  logic [7:0]        out_pixel_value;
  logic              out_clipped;

  bmp_rle_stream_decoder_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stream_byte    (in_stream_byte),
    .in_start_of_image (in_start_of_image),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segment_kind  (out_segment_kind),
    .out_row_index     (out_row_index),
    .out_start_column  (out_start_column),
    .out_pixel_count   (out_pixel_count),
    .out_pixel_value   (out_pixel_value),
    .out_clipped       (out_clipped)
  );

  always #5 clk = ~clk;

  byte_item_t       byte_q[$];
  seg_t             seg_q[$];
  byte_item_t       nxt;
  seg_t             want;
  seg_t             got;

  bit               dec_rle4 = 1'b0;
  logic [COL_W-1:0] dec_width = 13'd4096;
  dec_phase_t       dec_phase = P_FIRST;
  logic [7:0]       dec_held = 8'h00;
  logic [7:0]       dec_lit_left = 8'h00;
  logic [7:0]       dec_lit_total = 8'h00;
  int unsigned      dec_col = 0;
  int unsigned      dec_row = 0;
  bit               dec_done = 1'b0;

  int               tx_mode = 0;
  int               tx_burst = 0;
  int               tx_gap = 0;
  int               rx_mode = 0;
  int unsigned      rx_cyc = 0;
  int               hold_req = 0;
  int               hold_ack = 0;
  int               hold_left = 0;

  bit               next_sof = 1'b0;
  bit               lit_open = 1'b0;
  int               n_queued = 0;
  int               n_accepted = 0;
  int               n_results = 0;
  int               n_cfg_writes = 0;
  int               n_shown = 0;
  int               errors = 0;

  function automatic void push_seg(input logic [1:0] kind, input int unsigned n,
                                   input logic [7:0] val);
    int unsigned w;
    int unsigned avail;
    int unsigned keep;
    bit          clip;
    seg_t        s;
    w = (int'(dec_width) > MAX_WIDTH) ? MAX_WIDTH : int'(dec_width);
    avail = (dec_col < w) ? (w - dec_col) : 0;
    keep = 0;
    clip = 1'b0;
    if (kind == SEG_FILL || kind == SEG_LIT) begin
      keep = (n < avail) ? n : avail;
      clip = (n > avail);
    end
    s.kind = kind;
    s.row = dec_row[11:0];
    s.col = (dec_col > 4095) ? 12'd4095 : dec_col[11:0];
    s.cnt = keep[7:0];
    s.val = (kind == SEG_FILL || kind == SEG_LIT) ? val : 8'h00;
    s.clip = clip;
    seg_q.push_back(s);
  endfunction

  function automatic void bump_col(input int unsigned n);
    dec_col = (dec_col + n > COL_LIMIT) ? COL_LIMIT : dec_col + n;
  endfunction

  function automatic void bump_row(input int unsigned n);
    dec_row = (dec_row + n > ROW_LIMIT) ? ROW_LIMIT : dec_row + n;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic sof);
    int unsigned n;
    int unsigned nbytes;
    if (sof) begin
      dec_phase = P_FIRST;
      dec_held = 8'h00;
      dec_lit_left = 8'h00;
      dec_lit_total = 8'h00;
      dec_col = 0;
      dec_row = 0;
      dec_done = 1'b0;
    end
    if (dec_done) return;
    case (dec_phase)
      P_FIRST: begin
        dec_held = b;
        dec_phase = P_SECOND;
      end
      P_SECOND: begin
        dec_phase = P_FIRST;
        if (dec_held != 8'h00) begin
          push_seg(SEG_FILL, 32'(dec_held), b);
          bump_col(32'(dec_held));
        end else if (b == ESC_EOL) begin
          push_seg(SEG_EOL, 0, 8'h00);
          bump_row(1);
          dec_col = 0;
        end else if (b == ESC_EOB) begin
          push_seg(SEG_EOB, 0, 8'h00);
          dec_done = 1'b1;
        end else if (b == ESC_DELTA) begin
          dec_phase = P_DX;
        end else begin
          dec_lit_left = b;
          dec_lit_total = b;
          dec_phase = P_LIT;
        end
      end
      P_DX: begin
        dec_held = b;
        dec_phase = P_DY;
      end
      P_DY: begin
        bump_col(32'(dec_held));
        bump_row(32'(b));
        dec_phase = P_FIRST;
      end
      P_LIT: begin
        if (dec_rle4) n = (dec_lit_left >= 8'd2) ? 2 : 32'(dec_lit_left);
        else n = (dec_lit_left >= 8'd1) ? 1 : 0;
        push_seg(SEG_LIT, n, b);
        bump_col(n);
        dec_lit_left = dec_lit_left - n[7:0];
        if (dec_lit_left == 8'h00) begin
          nbytes = dec_rle4 ? ((32'(dec_lit_total) + 1) >> 1) : 32'(dec_lit_total);
          dec_phase = nbytes[0] ? P_PAD : P_FIRST;
        end
      end
      default: begin
        dec_phase = P_FIRST;
      end
    endcase
  endfunction

  // One transaction per accepted byte; the next byte is offered in the same step.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_stream_byte, in_start_of_image);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          in_stream_byte <= nxt.b;
          in_start_of_image <= nxt.sof;
          if (tx_burst > 0) begin
            tx_burst--;
          end else begin
            case (tx_mode)
              0: begin
                tx_burst = int'($urandom_range(20, 60));
                tx_gap = 0;
              end
              1: begin
                tx_burst = int'($urandom_range(0, 15));
                tx_gap = int'($urandom_range(0, 3));
              end
              default: begin
                tx_burst = int'($urandom_range(0, 5));
                tx_gap = int'($urandom_range(2, 24));
              end
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rx_cyc++;
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ((rx_cyc % 7) < 4);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      got.kind = out_segment_kind;
      got.row = out_row_index;
      got.col = out_start_column;
      got.cnt = out_pixel_count;
      got.val = out_pixel_value;
      got.clip = out_clipped;
      if (seg_q.size() == 0) begin
        errors++;
        if (n_shown < 10) begin
          $display("Unexpected segment: kind=%0d row=%0d col=%0d cnt=%0d val=%02h clip=%0b",
                   got.kind, got.row, got.col, got.cnt, got.val, got.clip);
        end
        n_shown++;
      end else begin
        want = seg_q.pop_front();
        if (got !== want) begin
          errors++;
          if (n_shown < 10) begin
            $display("Segment %0d mismatch: expected kind=%0d row=%0d col=%0d cnt=%0d val=%02h clip=%0b",
                     n_results, want.kind, want.row, want.col, want.cnt, want.val, want.clip);
            $display("                     actual   kind=%0d row=%0d col=%0d cnt=%0d val=%02h clip=%0b",
                     got.kind, got.row, got.col, got.cnt, got.val, got.clip);
          end
          n_shown++;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{sof: next_sof, b: b});
    next_sof = 1'b0;
    n_queued++;
  endtask

  task automatic push_pair(input logic [7:0] first, input logic [7:0] second);
    push_byte(first);
    push_byte(second);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [COL_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RLE4_MODE) dec_rle4 = data[0];
    else if (idx == CFG_ROW_WIDTH) dec_width = data;
    n_cfg_writes++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || seg_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic gen_stream(input int n_bytes, input bit fresh, input bit rle4);
    int start;
    int r;
    int cnt;
    int nb;
    start = n_queued;
    if (lit_open) begin
      repeat (6) push_byte(8'($urandom_range(0, 255)));
      lit_open = 1'b0;
      fresh = 1'b1;
    end
    if (fresh) next_sof = 1'b1;
    while (n_queued - start < n_bytes) begin
      r = int'($urandom_range(0, 99));
      if (r < 42) begin
        cnt = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 255))
                                          : int'($urandom_range(1, 16));
        if ($urandom_range(0, 29) == 0) cnt = 255;
        push_pair(8'(cnt), 8'($urandom_range(0, 255)));
      end else if (r < 62) begin
        cnt = ($urandom_range(0, 11) == 0) ? int'($urandom_range(13, 255))
                                           : int'($urandom_range(3, 12));
        if ($urandom_range(0, 39) == 0) cnt = 255;
        push_pair(ESCAPE, 8'(cnt));
        nb = rle4 ? (cnt + 1) / 2 : cnt;
        repeat (nb) push_byte(8'($urandom_range(0, 255)));
        if ((nb % 2) == 1 && $urandom_range(0, 9) != 0) push_byte(8'($urandom_range(0, 255)));
      end else if (r < 74) begin
        push_pair(ESCAPE, ESC_DELTA);
        push_pair(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 20)),
                  ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3)));
      end else if (r < 87) begin
        push_pair(ESCAPE, ESC_EOL);
      end else if (r < 91) begin
        if ($urandom_range(0, 1) == 1) next_sof = 1'b1;
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        push_pair(ESCAPE, ESC_EOB);
        push_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        next_sof = 1'b1;
      end else begin
        push_pair(8'($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      push_pair(ESCAPE, 8'd9);
      push_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      lit_open = 1'b1;
    end
  endtask

  initial begin
    int p;
    bit mode;
    logic [COL_W-1:0] width;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    next_sof = 1'b1;
    push_pair(8'h03, 8'h00);
    push_pair(8'hFF, 8'hFF);
    push_pair(ESCAPE, 8'd3);
    push_pair(8'hAA, 8'h55);
    push_pair(8'h0F, 8'h00);
    push_pair(ESCAPE, ESC_DELTA);
    push_pair(8'h05, 8'h01);
    push_pair(ESCAPE, ESC_EOL);
    push_pair(ESCAPE, ESC_EOB);
    push_byte(8'h7E);
    next_sof = 1'b1;
    push_pair(8'h01, 8'h81);
    wait_idle();

    cfg_write(CFG_RLE4_MODE, 13'd1);
    cfg_write(CFG_ROW_WIDTH, 13'd1);
    push_pair(ESCAPE, 8'd5);
    push_pair(8'h12, 8'h34);
    push_pair(8'hF0, 8'h0F);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      tx_mode = (p / 2) % 3;
      rx_mode = p % 4;
      mode = 1'(((p / 6) % 2) ^ (p % 2));
      case (p % 6)
        0: width = 13'd4096;
        1: width = 13'($urandom_range(1, 64));
        2: width = 13'd0;
        3: width = 13'd8191;
        4: width = 13'($urandom_range(1, 4096));
        default: width = 13'd1;
      endcase
      cfg_write(CFG_RLE4_MODE, 13'(mode));
      cfg_write(CFG_ROW_WIDTH, width);
      if (p == 3) hold_req++;
      if (p == 7) begin
        // Drive row and column into saturation, then keep decoding there.
        lit_open = 1'b0;
        next_sof = 1'b1;
        repeat (34) begin
          push_pair(ESCAPE, ESC_DELTA);
          push_pair(8'hFF, 8'd130);
        end
        push_pair(8'd5, 8'hC3);
        push_pair(ESCAPE, ESC_EOL);
        push_pair(8'd7, 8'h3C);
        push_pair(ESCAPE, ESC_EOL);
      end
      gen_stream(PHASE_BYTES, ($urandom_range(0, 3) != 0) || p == 0, mode);
      wait_idle();
    end

    errors += seg_q.size();
    $display("Checked %0d segments from %0d accepted bytes across %0d register writes.",
             n_results, n_accepted, n_cfg_writes);
    $display("Both pixel modes, widths from 0 to 8191, saturation and a long output stall were run.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
